// ===== sv/rgb_sobel_edge_magnitude_assert.svh =====
// Assertion macros for the RGB Sobel edge magnitude block.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef RGB_SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define RGB_SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rse assertion failed");

// Next-cycle implication, checked outside reset.
`define RSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rse assertion failed");

`endif

// ===== sv/rse_pkg.sv =====
// Shared types and constants of the RGB Sobel edge magnitude block.
// No dependencies.
`timescale 1ns / 1ps
package rse_pkg;
  localparam int MaxLine = 2048;
  localparam int ColW    = 11;
  localparam int RowW    = 12;
  localparam int PixW    = 24;
  localparam int ChW     = 8;
  localparam int WtW     = 16;
  localparam int GradW   = 11;
  localparam int SqW     = 21;
  localparam int RadW    = 38;
  localparam int RootW   = 19;
  localparam int RemW    = RootW + 2;
  localparam int StepW   = 5;
  localparam int ProdW   = RootW + WtW;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RED_W  = 3'd2;
  localparam logic [2:0] REG_GRN_W  = 3'd3;
  localparam logic [2:0] REG_BLU_W  = 3'd4;

  typedef logic [8:0][ChW-1:0] chan_win_t;
  typedef logic [8:0][PixW-1:0] pix_win_t;
endpackage

// ===== sv/rse_isqrt.sv =====
// Iterative floor square root, two radicand bits per cycle.
// Depends on rse_pkg.
`timescale 1ns / 1ps
module rse_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rse_pkg::RadW-1:0]   radicand,
  output logic                       done,
  output logic [rse_pkg::RootW-1:0]  root
);
  logic [rse_pkg::RadW-1:0]  rad_r;
  logic [rse_pkg::RemW-1:0]  rem_r;
  logic [rse_pkg::RootW-1:0] root_r;
  logic [rse_pkg::StepW-1:0] step_r;
  logic                      busy_r;
  logic                      done_r;
  logic [rse_pkg::RemW+1:0]  rem_sh;
  logic [rse_pkg::RemW+1:0]  trial;
  logic                      take;

  assign rem_sh = {rem_r, rad_r[rse_pkg::RadW-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == rse_pkg::StepW'(rse_pkg::RootW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[rse_pkg::RadW-3:0], 2'b00};
      if (take) begin
        rem_r  <= rse_pkg::RemW'(rem_sh - trial);
        root_r <= {root_r[rse_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_r  <= rse_pkg::RemW'(rem_sh);
        root_r <= {root_r[rse_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// ===== sv/rse_lane.sv =====
// One color lane: Sobel gradients, squared magnitude, square root, weight.
// Depends on rse_pkg and rse_isqrt.
`timescale 1ns / 1ps
module rse_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  rse_pkg::chan_win_t            win,
  input  logic [rse_pkg::WtW-1:0]       weight,
  output logic                          done,
  output logic [rse_pkg::ChW-1:0]       edge_val
);
  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_SQ   = 3'd1;
  localparam logic [2:0] L_GO   = 3'd2;
  localparam logic [2:0] L_ROOT = 3'd3;
  localparam logic [2:0] L_MUL  = 3'd4;
  localparam logic [2:0] L_OUT  = 3'd5;

  logic [2:0]                    st_r;
  logic signed [rse_pkg::GradW-1:0] gx, gy;
  logic [rse_pkg::SqW-1:0]       sqx_r, sqy_r;
  logic [rse_pkg::SqW-1:0]       mag;
  logic                          sq_start;
  logic                          sq_done;
  logic [rse_pkg::RootW-1:0]     root;
  logic [rse_pkg::ProdW-1:0]     prod_r;
  logic [rse_pkg::ChW-1:0]       edge_r;
  logic                          done_r;

  always_comb begin
    gx = rse_pkg::GradW'(signed'({3'b0, win[0]})) + (rse_pkg::GradW'(signed'({3'b0, win[3]})) <<< 1)
       + rse_pkg::GradW'(signed'({3'b0, win[6]})) - rse_pkg::GradW'(signed'({3'b0, win[2]}))
       - (rse_pkg::GradW'(signed'({3'b0, win[5]})) <<< 1) - rse_pkg::GradW'(signed'({3'b0, win[8]}));
    gy = rse_pkg::GradW'(signed'({3'b0, win[0]})) + (rse_pkg::GradW'(signed'({3'b0, win[1]})) <<< 1)
       + rse_pkg::GradW'(signed'({3'b0, win[2]})) - rse_pkg::GradW'(signed'({3'b0, win[6]}))
       - (rse_pkg::GradW'(signed'({3'b0, win[7]})) <<< 1) - rse_pkg::GradW'(signed'({3'b0, win[8]}));
  end

  assign mag      = sqx_r + sqy_r;
  assign sq_start = (st_r == L_GO);

  rse_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({1'b0, mag, 16'h0000}),
    .done     (sq_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        L_IDLE: if (start) st_r <= L_SQ;
        L_SQ:   st_r <= L_GO;
        L_GO:   st_r <= L_ROOT;
        L_ROOT: if (sq_done) st_r <= L_MUL;
        L_MUL:  st_r <= L_OUT;
        L_OUT: begin
          st_r   <= L_IDLE;
          done_r <= 1'b1;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  // Squares are registered in the cycle after start, when the window is settled;
  // the square root starts in the next cycle from the sum of those squares.
  always_ff @(posedge clk) begin
    if (st_r == L_SQ) begin
      sqx_r <= rse_pkg::SqW'((rse_pkg::SqW + 1)'(gx) * (rse_pkg::SqW + 1)'(gx));
      sqy_r <= rse_pkg::SqW'((rse_pkg::SqW + 1)'(gy) * (rse_pkg::SqW + 1)'(gy));
    end
    if (st_r == L_MUL) prod_r <= rse_pkg::ProdW'(root) * rse_pkg::ProdW'(weight);
    if (st_r == L_OUT) begin
      if (prod_r[rse_pkg::ProdW-1:32] != '0) edge_r <= 8'hff;
      else edge_r <= prod_r[31:24];
    end
  end

  assign done     = done_r;
  assign edge_val = edge_r;
endmodule

// ===== sv/rgb_sobel_edge_magnitude.sv =====
// Top level of the RGB Sobel edge magnitude block: counters, line stores,
// 3x3 window, three color lanes and the output merge. Depends on rse_pkg and rse_lane.
`timescale 1ns / 1ps
// Channel | Dir | Handshake             | Payload
// in      | in  | in_tvalid/in_tready   | in_tdata: red, green, blue (8 bits each)
// out     | out | out_tvalid/out_tready | out_tdata: red, green, blue edge; out_tlast
// cfg     | in  | cfg_valid/cfg_ready   | cfg_index (register), cfg_data
//
// A border pixel passes through accept, line store read and window update.
// An interior pixel then goes through the lanes: squaring, root start, the 19
// steps of each lane's square root unit, multiply and clamp, then the merge.
// The lanes for red, green and blue run side by side.
// Reset (synchronous, rst_n low) clears counters, window, state and output valid, and loads config defaults.
// The result sits in an output register, so the next pixel is taken while it
// waits; a stalled output only holds the block when the next result is due.
module rgb_sobel_edge_magnitude (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] red_edge, [15:8] green_edge, [23:16] blue_edge
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  `include "rgb_sobel_edge_magnitude_assert.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_LANE = 3'd3;
  localparam logic [2:0] ST_MRG  = 3'd4;

  logic [2:0]  state_r;
  logic [11:0] width_r, height_r;
  logic [rse_pkg::WtW-1:0] wt_r [3];

  logic [rse_pkg::ColW-1:0] col_r;
  logic [rse_pkg::RowW-1:0] row_r;
  logic [rse_pkg::PixW-1:0] pix_r, up_q_r, mid_q_r;
  rse_pkg::pix_win_t        win_r;
  logic                     last_r;

  logic [rse_pkg::PixW-1:0] upper_mem_r  [rse_pkg::MaxLine];
  logic [rse_pkg::PixW-1:0] middle_mem_r [rse_pkg::MaxLine];

  logic [11:0]              w_eff;
  logic [rse_pkg::ColW-1:0] w_m1;
  logic [rse_pkg::RowW-1:0] h_m1;
  logic                     line_end, frame_end, interior;
  logic                     lane_start;
  logic [2:0]               lane_done;
  logic [rse_pkg::ChW-1:0]  lane_edge [3];
  rse_pkg::chan_win_t       ch_win [3];

  logic                     out_valid_r, out_last_r;
  logic [23:0]              out_data_r;
  logic                     out_free;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // Effective frame size: width clamped to 3..2048, height raised to 3.
  always_comb begin
    if (width_r < 12'd3) w_eff = 12'd3;
    else if (width_r > 12'd2048) w_eff = 12'd2048;
    else w_eff = width_r;
    w_m1 = rse_pkg::ColW'(w_eff - 12'd1);
    h_m1 = (height_r < 12'd3) ? 12'd2 : height_r - 12'd1;
  end

  assign line_end   = col_r >= w_m1;
  assign frame_end  = line_end && (row_r >= h_m1);
  assign interior   = (row_r >= 12'd2) && (col_r >= 11'd2);
  assign lane_start = (state_r == ST_UPD) && interior;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 12'd480;
      wt_r[0]  <= 16'd13926;
      wt_r[1]  <= 16'd46884;
      wt_r[2]  <= 16'd4725;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rse_pkg::REG_WIDTH:  width_r  <= cfg_data[11:0];
        rse_pkg::REG_HEIGHT: height_r <= cfg_data[11:0];
        rse_pkg::REG_RED_W:  wt_r[0]  <= cfg_data;
        rse_pkg::REG_GRN_W:  wt_r[1]  <= cfg_data;
        rse_pkg::REG_BLU_W:  wt_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line stores: read in ST_RD, written back in ST_UPD at the same column.
  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      up_q_r  <= upper_mem_r[col_r];
      mid_q_r <= middle_mem_r[col_r];
    end
    if (state_r == ST_UPD) begin
      upper_mem_r[col_r]  <= mid_q_r;
      middle_mem_r[col_r] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) pix_r <= in_tdata;
  end

  // Sequencer, counters and window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      win_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_tvalid) state_r <= ST_RD;
        ST_RD:   state_r <= ST_UPD;
        ST_UPD: begin
          for (int r = 0; r < 3; r++) begin
            win_r[r*3]   <= win_r[r*3+1];
            win_r[r*3+1] <= win_r[r*3+2];
          end
          win_r[2] <= up_q_r;
          win_r[5] <= mid_q_r;
          win_r[8] <= pix_r;
          last_r   <= frame_end;
          if (frame_end) begin
            col_r <= '0;
            row_r <= '0;
          end else if (line_end) begin
            col_r <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
          state_r <= interior ? ST_LANE : ST_IDLE;
        end
        ST_LANE: if (lane_done[0]) state_r <= ST_MRG;
        ST_MRG:  if (out_free) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // One lane per color channel, each seeing its byte of every window cell.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 9; i++) begin
        ch_win[k][i] = win_r[i][k*8 +: 8];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    rse_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (lane_start),
      .win      (ch_win[k]),
      .weight   (wt_r[k]),
      .done     (lane_done[k]),
      .edge_val (lane_edge[k])
    );
  end

  // Merge: the three lane results and the frame flag form one output beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_MRG && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MRG && out_free) begin
      out_data_r <= {lane_edge[2], lane_edge[1], lane_edge[0]};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `RSE_ASSERT_NOW(a_lanes_in_step, lane_done[0], lane_done[1] && lane_done[2])
  `RSE_ASSERT_NOW(a_done_in_lane_state, lane_done[0], state_r == ST_LANE)
  `RSE_ASSERT_NEXT(a_merge_waits, state_r == ST_MRG && out_valid_r && !out_tready,
                   state_r == ST_MRG)
endmodule
